FILE: rtl/core/lsq_pkg.sv
// shared types and constants of the lane supersede priority job queue
package lsq_pkg;

    localparam int CMD_W    = 2;
    localparam int KIND_W   = 3;
    localparam int JOB_ID_W = 32;
    localparam int ORD_W    = 32;
    localparam int PEND_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE  = 2'd0,
        CMD_DISPATCH = 2'd1,
        CMD_CANCEL   = 2'd2
    } cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED   = 3'd0,
        KIND_REJECTED   = 3'd1,
        KIND_FULL       = 3'd2,
        KIND_SUPERSEDED = 3'd3,
        KIND_CANCELED   = 3'd4,
        KIND_DISPATCHED = 3'd5,
        KIND_EMPTY      = 3'd6,
        KIND_NONE       = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENQ,
        ST_CAN,
        ST_SCAN,
        ST_DISP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        kind_t                kind;
        logic [JOB_ID_W-1:0]  job_id;
        logic [JOB_ID_W-1:0]  repl_id;
        logic                 lane;
        logic                 prio;
    } res_t;

endpackage

FILE: rtl/core/lsq_slots.sv
// per-lane job slots: valid flags, job id, priority and arrival ordinal
module lsq_slots #(
    parameter int NUM_LANES = 2,
    parameter int ID_WIDTH  = 32,
    localparam int LANE_W   = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [LANE_W-1:0]           rd_addr,
    output logic                        rd_valid,
    output logic [ID_WIDTH-1:0]         rd_id,
    output logic                        rd_prio,
    output logic [lsq_pkg::ORD_W-1:0]   rd_ord,
    input  logic                        wr_en,
    input  logic                        wr_set,
    input  logic [LANE_W-1:0]           wr_addr,
    input  logic [ID_WIDTH-1:0]         wr_id,
    input  logic                        wr_prio,
    input  logic [lsq_pkg::ORD_W-1:0]   wr_ord
);

    logic [NUM_LANES-1:0]        valid_reg;
    logic [ID_WIDTH-1:0]         id_reg   [NUM_LANES];
    logic                        prio_reg [NUM_LANES];
    logic [lsq_pkg::ORD_W-1:0]   ord_reg  [NUM_LANES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= wr_set;
        end
    end

    // payload only changes on a set, no reset needed
    always_ff @(posedge aclk) begin
        if (wr_en && wr_set) begin
            id_reg[wr_addr]   <= wr_id;
            prio_reg[wr_addr] <= wr_prio;
            ord_reg[wr_addr]  <= wr_ord;
        end
    end

    assign rd_valid = valid_reg[rd_addr];
    assign rd_id    = id_reg[rd_addr];
    assign rd_prio  = prio_reg[rd_addr];
    assign rd_ord   = ord_reg[rd_addr];

endmodule

FILE: rtl/core/lsq_cmp.sv
// shared compare unit: does the candidate slot beat the best so far
module lsq_cmp (
    input  logic                        cand_valid,
    input  logic                        cand_prio,
    input  logic [lsq_pkg::ORD_W-1:0]   cand_ord,
    input  logic                        best_found,
    input  logic                        best_prio,
    input  logic [lsq_pkg::ORD_W-1:0]   best_ord,
    output logic                        take
);

    logic [lsq_pkg::ORD_W-1:0] age_diff;
    logic                      older;

    // wrap-safe age test on the sign of the ordinal difference
    assign age_diff = cand_ord - best_ord;
    assign older    = age_diff[lsq_pkg::ORD_W-1];

    assign take = cand_valid &&
                  (!best_found ||
                   (cand_prio && !best_prio) ||
                   ((cand_prio == best_prio) && older));

endmodule

FILE: rtl/core/lane_supersede_priority_job_queue.sv
// top level of the lane supersede priority job queue
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  s_       | in        | s_tvalid / s_tready        | s_tuser command, s_tdata request
//  m_       | out       | m_tvalid / m_tready/m_tlast| m_tuser kind, m_tdata job report
//  cfg_     | in        | cfg_wr_en (no wait)        | cfg_wr_data max_pending
//
// one item at a time: accept, then a work state for a valid enqueue or a cancel, then
// its results in turn; dispatch instead walks the slots through the shared
// compare unit, one lane a cycle, then a dispatch state and its result;
// a valid enqueue gives 1 or 2 results, a rejected enqueue goes straight to its
// result, a cancel gives 1, an unused command none
// reset (aresetn low, synchronous) empties all slots, ids restart at one
// a stalled result holds the sequencer in the emit state; nothing is accepted then
module lane_supersede_priority_job_queue #(
    parameter int NUM_LANES = 2,
    parameter int ID_WIDTH  = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request channel
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // lane, priority_req, snapshot_ok, zero fill
    input  logic [1:0]   s_tuser,   // command
    // result channel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // job_id, replacement_id, job_lane, job_priority,
                                    // pending_count, pending_high_water, zero fill
    output logic [2:0]   m_tuser,   // kind
    output logic         m_tlast,
    // configuration
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data  // max_pending
);

    localparam int LANE_W = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
    localparam int PW     = lsq_pkg::PEND_W;
    localparam int OW     = lsq_pkg::ORD_W;

    // sequencer state
    lsq_pkg::state_t state_reg, state_next;

    // latched request
    logic              lane_reg, lane_next;
    logic              prio_reg, prio_next;

    // queue bookkeeping
    logic [ID_WIDTH-1:0] next_id_reg, next_id_next;
    logic [OW-1:0]       next_ord_reg, next_ord_next;
    logic [PW-1:0]       pending_reg, pending_next;
    logic [PW-1:0]       hw_reg, hw_next;
    logic [PW-1:0]       max_pend_reg;

    // scan state for dispatch
    logic [LANE_W-1:0]   scan_idx_reg, scan_idx_next;
    logic                best_found_reg, best_found_next;
    logic [LANE_W-1:0]   best_idx_reg, best_idx_next;
    logic                best_prio_reg, best_prio_next;
    logic [OW-1:0]       best_ord_reg, best_ord_next;
    logic [ID_WIDTH-1:0] best_id_reg, best_id_next;

    // result buffer: up to two results per item
    lsq_pkg::res_t res0_reg, res0_next;
    lsq_pkg::res_t res1_reg, res1_next;
    logic          two_reg, two_next;
    logic          emit_idx_reg, emit_idx_next;

    // slot store ports
    logic [LANE_W-1:0]   rd_addr;
    logic                rd_valid;
    logic [ID_WIDTH-1:0] rd_id;
    logic                rd_prio;
    logic [OW-1:0]       rd_ord;
    logic                wr_en;
    logic                wr_set;
    logic [LANE_W-1:0]   wr_addr;
    logic [ID_WIDTH-1:0] wr_id;
    logic                wr_prio;
    logic [OW-1:0]       wr_ord;

    logic                take;
    logic [LANE_W-1:0]   lane_idx;
    logic                in_lane_ok;
    logic                reg_lane_ok;
    lsq_pkg::res_t       out_res;

    assign lane_idx    = LANE_W'(lane_reg);
    assign in_lane_ok  = (int'(s_tdata[0]) < NUM_LANES);
    assign reg_lane_ok = (int'(lane_reg) < NUM_LANES);

    lsq_slots #(
        .NUM_LANES (NUM_LANES),
        .ID_WIDTH  (ID_WIDTH)
    ) u_slots (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_valid (rd_valid),
        .rd_id    (rd_id),
        .rd_prio  (rd_prio),
        .rd_ord   (rd_ord),
        .wr_en    (wr_en),
        .wr_set   (wr_set),
        .wr_addr  (wr_addr),
        .wr_id    (wr_id),
        .wr_prio  (wr_prio),
        .wr_ord   (wr_ord)
    );

    lsq_cmp u_cmp (
        .cand_valid (rd_valid),
        .cand_prio  (rd_prio),
        .cand_ord   (rd_ord),
        .best_found (best_found_reg),
        .best_prio  (best_prio_reg),
        .best_ord   (best_ord_reg),
        .take       (take)
    );

    // registers with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= lsq_pkg::ST_IDLE;
            next_id_reg  <= ID_WIDTH'(1);
            next_ord_reg <= '0;
            pending_reg  <= '0;
            hw_reg       <= '0;
            max_pend_reg <= PW'(2);
            emit_idx_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_id_reg  <= next_id_next;
            next_ord_reg <= next_ord_next;
            pending_reg  <= pending_next;
            hw_reg       <= hw_next;
            emit_idx_reg <= emit_idx_next;
            if (cfg_wr_en) begin
                max_pend_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        lane_reg       <= lane_next;
        prio_reg       <= prio_next;
        scan_idx_reg   <= scan_idx_next;
        best_found_reg <= best_found_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_ord_reg   <= best_ord_next;
        best_id_reg    <= best_id_next;
        res0_reg       <= res0_next;
        res1_reg       <= res1_next;
        two_reg        <= two_next;
    end

    // sequencer
    always_comb begin
        logic [PW-1:0]  pend_ev;
        lsq_pkg::res_t  r_new;

        state_next      = state_reg;
        lane_next       = lane_reg;
        prio_next       = prio_reg;
        next_id_next    = next_id_reg;
        next_ord_next   = next_ord_reg;
        pending_next    = pending_reg;
        hw_next         = hw_reg;
        scan_idx_next   = scan_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_ord_next   = best_ord_reg;
        best_id_next    = best_id_reg;
        res0_next       = res0_reg;
        res1_next       = res1_reg;
        two_next        = two_reg;
        emit_idx_next   = emit_idx_reg;

        s_tready = 1'b0;
        m_tvalid = 1'b0;
        rd_addr  = lane_idx;
        wr_en    = 1'b0;
        wr_set   = 1'b0;
        wr_addr  = lane_idx;
        wr_id    = next_id_reg;
        wr_prio  = prio_reg;
        wr_ord   = next_ord_reg;
        pend_ev  = pending_reg - PW'(rd_valid);
        r_new    = '0;

        case (state_reg)
            lsq_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    lane_next = s_tdata[0];
                    prio_next = s_tdata[1];
                    two_next  = 1'b0;
                    case (lsq_pkg::cmd_t'(s_tuser))
                        lsq_pkg::CMD_ENQUEUE: begin
                            if (s_tdata[2] && in_lane_ok) begin
                                state_next = lsq_pkg::ST_ENQ;
                            end else begin
                                // bad snapshot or lane: no id used
                                r_new.kind = lsq_pkg::KIND_REJECTED;
                                r_new.lane = s_tdata[0];
                                r_new.prio = s_tdata[1];
                                res0_next  = r_new;
                                state_next = lsq_pkg::ST_EMIT;
                            end
                        end
                        lsq_pkg::CMD_DISPATCH: begin
                            scan_idx_next   = '0;
                            best_found_next = 1'b0;
                            state_next      = lsq_pkg::ST_SCAN;
                        end
                        lsq_pkg::CMD_CANCEL: begin
                            state_next = lsq_pkg::ST_CAN;
                        end
                        default: begin
                            state_next = lsq_pkg::ST_IDLE;
                        end
                    endcase
                end
            end

            lsq_pkg::ST_ENQ: begin
                next_id_next = next_id_reg + ID_WIDTH'(1);
                // evict the lane's queued job first
                res0_next.kind    = lsq_pkg::KIND_SUPERSEDED;
                res0_next.job_id  = lsq_pkg::JOB_ID_W'(rd_id);
                res0_next.repl_id = lsq_pkg::JOB_ID_W'(next_id_reg);
                res0_next.lane    = lane_reg;
                res0_next.prio    = rd_prio;
                r_new.job_id      = lsq_pkg::JOB_ID_W'(next_id_reg);
                r_new.lane        = lane_reg;
                r_new.prio        = prio_reg;
                wr_en             = rd_valid;
                if (pend_ev >= max_pend_reg) begin
                    r_new.kind   = lsq_pkg::KIND_FULL;
                    pending_next = pend_ev;
                end else begin
                    r_new.kind    = lsq_pkg::KIND_ACCEPTED;
                    wr_en         = 1'b1;
                    wr_set        = 1'b1;
                    next_ord_next = next_ord_reg + OW'(1);
                    pending_next  = pend_ev + PW'(1);
                end
                if (rd_valid) begin
                    res1_next = r_new;
                    two_next  = 1'b1;
                end else begin
                    res0_next = r_new;
                end
                state_next = lsq_pkg::ST_EMIT;
            end

            lsq_pkg::ST_CAN: begin
                r_new.lane = lane_reg;
                if (reg_lane_ok && rd_valid) begin
                    wr_en        = 1'b1;
                    pending_next = pending_reg - PW'(1);
                    r_new.kind   = lsq_pkg::KIND_CANCELED;
                    r_new.job_id = lsq_pkg::JOB_ID_W'(rd_id);
                    r_new.prio   = rd_prio;
                end else begin
                    r_new.kind   = lsq_pkg::KIND_NONE;
                end
                res0_next  = r_new;
                state_next = lsq_pkg::ST_EMIT;
            end

            lsq_pkg::ST_SCAN: begin
                rd_addr = scan_idx_reg;
                if (take) begin
                    best_found_next = 1'b1;
                    best_idx_next   = scan_idx_reg;
                    best_prio_next  = rd_prio;
                    best_ord_next   = rd_ord;
                    best_id_next    = rd_id;
                end
                if (scan_idx_reg == LANE_W'(NUM_LANES - 1)) begin
                    state_next = lsq_pkg::ST_DISP;
                end else begin
                    scan_idx_next = scan_idx_reg + LANE_W'(1);
                end
            end

            lsq_pkg::ST_DISP: begin
                wr_addr = best_idx_reg;
                if (best_found_reg) begin
                    wr_en        = 1'b1;
                    pending_next = pending_reg - PW'(1);
                    r_new.kind   = lsq_pkg::KIND_DISPATCHED;
                    r_new.job_id = lsq_pkg::JOB_ID_W'(best_id_reg);
                    r_new.lane   = best_idx_reg[0];
                    r_new.prio   = best_prio_reg;
                end else begin
                    r_new.kind   = lsq_pkg::KIND_EMPTY;
                end
                res0_next  = r_new;
                state_next = lsq_pkg::ST_EMIT;
            end

            lsq_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (emit_idx_reg == two_reg) begin
                        emit_idx_next = 1'b0;
                        state_next    = lsq_pkg::ST_IDLE;
                    end else begin
                        emit_idx_next = 1'b1;
                    end
                end
            end

            default: begin
                state_next = lsq_pkg::ST_IDLE;
            end
        endcase

        // high water tracks the count left by each step
        if (pending_next > hw_reg) begin
            hw_next = pending_next;
        end
    end

    // result channel: bookkeeping registers already hold the post-step values
    assign out_res = emit_idx_reg ? res1_reg : res0_reg;
    assign m_tuser = out_res.kind;
    assign m_tlast = (emit_idx_reg == two_reg);
    assign m_tdata = {4'b0, hw_reg, pending_reg, out_res.prio, out_res.lane,
                      out_res.repl_id, out_res.job_id};

    // checks
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while a result is pending");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(pending_reg) <= NUM_LANES)
        else $error("pending count beyond lane count");

    a_high_water: assert property (@(posedge aclk) disable iff (!aresetn)
        hw_reg >= pending_reg)
        else $error("high water below pending count");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result after final item of a request");

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the lane supersede priority job queue
module testbench;

    localparam int HALF_PERIOD = 2;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_SHOWN = 10;
    localparam int PHASE_ITEMS = 260;
    localparam logic [lsq_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        lsq_pkg::kind_t               kind;
        logic [lsq_pkg::JOB_ID_W-1:0] job_id;
        logic [lsq_pkg::JOB_ID_W-1:0] repl_id;
        logic                         lane;
        logic                         prio;
        logic [lsq_pkg::PEND_W-1:0]   pending;
        logic [lsq_pkg::PEND_W-1:0]   high_water;
        logic                         last;
    } job_report_t;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_RARELY,
        READY_TOGGLE
    } ready_style_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [7:0]    s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [79:0]   m_tdata;
    logic [2:0]    m_tuser;
    logic          m_tlast;
    logic          cfg_wr_en = 1'b0;
    logic [4:0]    cfg_wr_data = '0;

    always #HALF_PERIOD aclk = ~aclk;

    lane_supersede_priority_job_queue dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // own copy of the queue state
    bit                           slot_busy [2];
    bit [lsq_pkg::JOB_ID_W-1:0]   slot_id [2];
    bit                           slot_pri [2];
    bit [lsq_pkg::ORD_W-1:0]      slot_age [2];
    bit [lsq_pkg::JOB_ID_W-1:0]   id_counter;
    bit [lsq_pkg::ORD_W-1:0]      arrival_counter;
    bit [lsq_pkg::PEND_W-1:0]     peak_pending;
    bit [lsq_pkg::PEND_W-1:0]     pending_limit;
    job_report_t                  expected_reports [$];

    int        faults = 0;
    int        items_sent = 0;
    int        reports_seen = 0;
    int        cycle_count = 0;
    bit [7:0]  kinds_seen = '0;
    int        burst_left = 0;
    int        hold_token = 0;

    function automatic int jobs_waiting();
        return int'(slot_busy[0]) + int'(slot_busy[1]);
    endfunction

    function automatic job_report_t make_report(lsq_pkg::kind_t k,
                                                bit [lsq_pkg::JOB_ID_W-1:0] id,
                                                bit [lsq_pkg::JOB_ID_W-1:0] repl,
                                                bit lane, bit pri);
        job_report_t r;
        r.kind = k;
        r.job_id = id;
        r.repl_id = repl;
        r.lane = lane;
        r.prio = pri;
        r.pending = '0;
        r.high_water = '0;
        r.last = 1'b0;
        return r;
    endfunction

    // work out the reports one command causes and queue them up
    function automatic void predict_command(logic [lsq_pkg::CMD_W-1:0] cmd, bit lane, bit pri,
                                            bit ok);
        job_report_t batch [2];
        int n;
        int best;
        bit [lsq_pkg::JOB_ID_W-1:0] fresh;
        bit [lsq_pkg::ORD_W-1:0] age_gap;
        n = 0;
        case (cmd)
            lsq_pkg::CMD_ENQUEUE: begin
                if (!ok) begin
                    batch[n++] = make_report(lsq_pkg::KIND_REJECTED, '0, '0, lane, pri);
                end else begin
                    fresh = id_counter;
                    id_counter++;
                    if (slot_busy[lane]) begin
                        batch[n++] = make_report(lsq_pkg::KIND_SUPERSEDED, slot_id[lane], fresh,
                                                 lane, slot_pri[lane]);
                        slot_busy[lane] = 1'b0;
                    end
                    if (jobs_waiting() >= int'(pending_limit)) begin
                        batch[n++] = make_report(lsq_pkg::KIND_FULL, fresh, '0, lane, pri);
                    end else begin
                        slot_busy[lane] = 1'b1;
                        slot_id[lane] = fresh;
                        slot_pri[lane] = pri;
                        slot_age[lane] = arrival_counter;
                        arrival_counter++;
                        batch[n++] = make_report(lsq_pkg::KIND_ACCEPTED, fresh, '0, lane, pri);
                    end
                end
            end
            lsq_pkg::CMD_DISPATCH: begin
                best = -1;
                for (int i = 0; i < 2; i++) begin
                    if (slot_busy[i]) begin
                        if (best < 0) begin
                            best = i;
                        end else begin
                            // oldest wins on equal priority, by sign of the age difference
                            age_gap = slot_age[i] - slot_age[best];
                            if (slot_pri[i] > slot_pri[best] ||
                                (slot_pri[i] == slot_pri[best] &&
                                 age_gap[lsq_pkg::ORD_W-1]))
                                best = i;
                        end
                    end
                end
                if (best < 0) begin
                    batch[n++] = make_report(lsq_pkg::KIND_EMPTY, '0, '0, 1'b0, 1'b0);
                end else begin
                    slot_busy[best] = 1'b0;
                    batch[n++] = make_report(lsq_pkg::KIND_DISPATCHED, slot_id[best], '0,
                                             best == 1, slot_pri[best]);
                end
            end
            lsq_pkg::CMD_CANCEL: begin
                if (slot_busy[lane]) begin
                    slot_busy[lane] = 1'b0;
                    batch[n++] = make_report(lsq_pkg::KIND_CANCELED, slot_id[lane], '0,
                                             lane, slot_pri[lane]);
                end else begin
                    batch[n++] = make_report(lsq_pkg::KIND_NONE, '0, '0, lane, 1'b0);
                end
            end
            default: ;
        endcase
        if (n == 0)
            return;
        if (jobs_waiting() > int'(peak_pending))
            peak_pending = lsq_pkg::PEND_W'(jobs_waiting());
        for (int k = 0; k < n; k++) begin
            batch[k].pending = lsq_pkg::PEND_W'(jobs_waiting());
            batch[k].high_water = peak_pending;
            batch[k].last = (k == n - 1);
            expected_reports.insert(expected_reports.size(), batch[k]);
        end
    endfunction

    // result checker, sampled at the rising edge
    always @(posedge aclk) begin
        job_report_t want;
        job_report_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = lsq_pkg::kind_t'(m_tuser);
            got.job_id = m_tdata[31:0];
            got.repl_id = m_tdata[63:32];
            got.lane = m_tdata[64];
            got.prio = m_tdata[65];
            got.pending = m_tdata[70:66];
            got.high_water = m_tdata[75:71];
            got.last = m_tlast;
            reports_seen++;
            kinds_seen[m_tuser] = 1'b1;
            if (expected_reports.size() == 0) begin
                faults++;
                if (faults <= MAX_SHOWN)
                    $display("unexpected report: kind %0d id %0d at cycle %0d",
                             got.kind, got.job_id, cycle_count);
            end else begin
                want = expected_reports.pop_front();
                if (got.kind !== want.kind || got.job_id !== want.job_id ||
                    got.repl_id !== want.repl_id || got.lane !== want.lane ||
                    got.prio !== want.prio || got.pending !== want.pending ||
                    got.high_water !== want.high_water || got.last !== want.last) begin
                    faults++;
                    if (faults <= MAX_SHOWN) begin
                        $display("mismatch at cycle %0d (kind id repl lane prio pend peak last)",
                                 cycle_count);
                        $display("  expected %0d %0d %0d %0d %0d %0d %0d %0d", want.kind,
                                 want.job_id, want.repl_id, want.lane, want.prio,
                                 want.pending, want.high_water, want.last);
                        $display("  actual   %0d %0d %0d %0d %0d %0d %0d %0d", got.kind,
                                 got.job_id, got.repl_id, got.lane, got.prio,
                                 got.pending, got.high_water, got.last);
                    end
                end
            end
        end
    end

    // receiver: changing stall style, plus a long hold-off on request
    ready_style_t ready_style = READY_ALWAYS;
    int style_left = 0;
    int hold_seen = 0;
    int hold_left = 0;

    always @(negedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                ready_style = ready_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 200);
            end
            style_left--;
            case (ready_style)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                READY_RARELY: m_tready <= ($urandom_range(0, 3) == 0);
                default:      m_tready <= ~m_tready;
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d reports outstanding", expected_reports.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // offer one request, in bursts with random gaps; returns just after the handshake
    task automatic send_item(logic [lsq_pkg::CMD_W-1:0] cmd, bit lane, bit pri, bit ok);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 2);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {5'b0, ok, pri, lane};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        predict_command(cmd, lane, pri, ok);
    endtask

    // mostly valid enqueues, with dispatch, cancel, bad snapshots and unused codes mixed in
    task automatic send_random_item();
        int pick;
        bit lane;
        bit pri;
        pick = $urandom_range(0, 99);
        lane = 1'($urandom_range(0, 1));
        pri = 1'($urandom_range(0, 1));
        if (pick < 50)
            send_item(lsq_pkg::CMD_ENQUEUE, lane, pri, 1'b1);
        else if (pick < 58)
            send_item(lsq_pkg::CMD_ENQUEUE, lane, pri, 1'b0);
        else if (pick < 78)
            send_item(lsq_pkg::CMD_DISPATCH, lane, pri, 1'($urandom_range(0, 1)));
        else if (pick < 95)
            send_item(lsq_pkg::CMD_CANCEL, lane, pri, 1'($urandom_range(0, 1)));
        else
            send_item(CMD_UNUSED, lane, pri, 1'($urandom_range(0, 1)));
    endtask

    // sender stops until every expected report is in, then lets the block settle
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_limit(bit [lsq_pkg::PEND_W-1:0] limit);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= limit;
        pending_limit = limit;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // every command and every report kind but full at the reset limit of two
    task automatic test_directed_commands();
        send_item(lsq_pkg::CMD_DISPATCH, 1'b0, 1'b0, 1'b0);   // empty queue
        send_item(lsq_pkg::CMD_CANCEL, 1'b0, 1'b0, 1'b0);     // nothing to cancel
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b0, 1'b0, 1'b0);    // bad snapshot
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b1, 1'b1, 1'b0);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b0, 1'b0, 1'b1);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b1, 1'b0, 1'b1);
        send_item(lsq_pkg::CMD_DISPATCH, 1'b1, 1'b1, 1'b1);   // equal priority, older lane first
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b0, 1'b1, 1'b1);
        send_item(lsq_pkg::CMD_DISPATCH, 1'b0, 1'b0, 1'b0);   // higher priority first
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b0, 1'b0, 1'b1);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b1, 1'b1, 1'b1);    // replaces the lane's job
        send_item(CMD_UNUSED, 1'b1, 1'b1, 1'b1);
        send_item(lsq_pkg::CMD_DISPATCH, 1'b0, 1'b0, 1'b0);
        send_item(lsq_pkg::CMD_DISPATCH, 1'b0, 1'b0, 1'b0);
        send_item(lsq_pkg::CMD_DISPATCH, 1'b0, 1'b0, 1'b0);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b1, 1'b1, 1'b1);
        send_item(lsq_pkg::CMD_CANCEL, 1'b1, 1'b0, 1'b0);
        send_item(lsq_pkg::CMD_CANCEL, 1'b1, 1'b1, 1'b1);
    endtask

    // full refusals at the limit extremes, including eviction followed by refusal
    task automatic test_limit_extremes();
        set_limit(5'd16);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b0, 1'b1, 1'b1);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b1, 1'b1, 1'b1);
        set_limit(5'd1);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b0, 1'b0, 1'b1);
        send_item(lsq_pkg::CMD_DISPATCH, 1'b0, 1'b0, 1'b0);
        set_limit(5'd0);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b1, 1'b0, 1'b1);
        send_item(lsq_pkg::CMD_DISPATCH, 1'b0, 1'b0, 1'b0);
        set_limit(5'd1);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b1, 1'b0, 1'b1);
        send_item(lsq_pkg::CMD_ENQUEUE, 1'b0, 1'b1, 1'b1);
        send_item(lsq_pkg::CMD_CANCEL, 1'b1, 1'b0, 1'b0);
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        set_limit(5'd2);
        @(posedge aclk);
        hold_token++;
        repeat (40) send_random_item();
        drain_results();
    endtask

    task automatic test_random_traffic();
        bit [lsq_pkg::PEND_W-1:0] limits [7] = '{5'd2, 5'd15, 5'd1, 5'd16, 5'd0, 5'd3, 5'd2};
        foreach (limits[p]) begin
            set_limit(limits[p]);
            repeat (PHASE_ITEMS) begin
                send_random_item();
                if ($urandom_range(0, 119) == 0)
                    drain_results();
            end
        end
    endtask

    initial begin
        slot_busy = '{default: 1'b0};
        id_counter = lsq_pkg::JOB_ID_W'(1);
        arrival_counter = '0;
        peak_pending = '0;
        pending_limit = 5'd2;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_commands();
        test_limit_extremes();
        test_backpressure();
        test_random_traffic();
        drain_results();

        if (expected_reports.size() != 0) begin
            faults += expected_reports.size();
            $display("%0d expected reports never arrived", expected_reports.size());
        end
        $display("run covered %0d requests and %0d reports, limits from 0 to 16",
                 items_sent, reports_seen);
        $display("report kinds seen %b, peak queue depth %0d", kinds_seen, peak_pending);
        if (faults == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d faults", faults);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
